// ===== rtl/cpf_pkg.sv =====
package cpf_pkg;

	// Default store depth and the hard packet size limit
	localparam int BUF_DEPTH_DEF = 20;
	localparam int PKT_MAX       = 20;

	// Field widths
	localparam int CNT_W  = 5;
	localparam int TICK_W = 16;
	localparam int BYTE_W = 8;
	localparam int REG_W  = 3;

	localparam logic [BYTE_W-1:0] START_MARK = 8'h21;

	// Input opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Result status codes
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NO_DATA  = 2'd1;
	localparam logic [1:0] STS_NO_START = 2'd2;
	localparam logic [1:0] STS_BAD_SUM  = 2'd3;

	// Configuration register indexes
	localparam logic [REG_W-1:0] REG_STOP_CODE    = 3'd0;
	localparam logic [REG_W-1:0] REG_STOP_LEN     = 3'd1;
	localparam logic [REG_W-1:0] REG_CONTROL_CODE = 3'd2;
	localparam logic [REG_W-1:0] REG_CONTROL_LEN  = 3'd3;
	localparam logic [REG_W-1:0] REG_KEY_CODE     = 3'd4;
	localparam logic [REG_W-1:0] REG_KEY_LEN      = 3'd5;
	localparam logic [REG_W-1:0] REG_SPEED_CODE   = 3'd6;
	localparam logic [REG_W-1:0] REG_SPEED_LEN    = 3'd7;

	localparam logic [CNT_W-1:0] LEN_RESET = 5'd5;

	// One configuration write
	typedef struct packed {
		logic              valid;
		logic [REG_W-1:0]  index;
		logic [BYTE_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== rtl/cpf_cfg.sv =====
module cpf_cfg import cpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           wr,
	input  logic [BYTE_W-1:0] type_byte,
	input  logic [CNT_W-1:0]  count,
	output logic              type_hit
);

	logic [BYTE_W-1:0] code_q [4];
	logic [CNT_W-1:0]  len_q  [4];

	// Type code and length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < 4; t++) begin
				code_q[t] <= '0;
				len_q[t]  <= LEN_RESET;
			end
		end else if (wr.valid) begin
			case (wr.index)
				REG_STOP_CODE:    code_q[0] <= wr.data;
				REG_STOP_LEN:     len_q[0]  <= wr.data[CNT_W-1:0];
				REG_CONTROL_CODE: code_q[1] <= wr.data;
				REG_CONTROL_LEN:  len_q[1]  <= wr.data[CNT_W-1:0];
				REG_KEY_CODE:     code_q[2] <= wr.data;
				REG_KEY_LEN:      len_q[2]  <= wr.data[CNT_W-1:0];
				REG_SPEED_CODE:   code_q[3] <= wr.data;
				REG_SPEED_LEN:    len_q[3]  <= wr.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Packet type seen and its length reached
	always_comb begin
		type_hit = 1'b0;
		for (int t = 0; t < 4; t++) begin
			if (type_byte == code_q[t] && count == len_q[t])
				type_hit = 1'b1;
		end
	end

endmodule

// ===== rtl/cpf_store.sv =====
module cpf_store import cpf_pkg::*; #(
	parameter int DEPTH = BUF_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/command_packet_framer_unit.sv =====
// Command packet framer. A start item (opcode 0) arms a read with a tick
// timeout; byte items (opcode 1) are written to a packet store, a '!' byte
// restarting at position 0; tick items (opcode 2) count the timeout down.
// When the store fills, a configured type/length pair matches, or the timeout
// expires, the packet is checked (data present, leading '!', last byte equal
// to the inverted 8-bit sum of the rest). A good packet streams out one
// result per byte, marked last on the final one; otherwise one status result
// is given. A start item, and a byte or tick item during a read, is handled in
// the accept cycle, which updates the counters and for a byte writes the store,
// and then in the check state, which evaluates the end condition in the next
// cycle. An ignored item (a byte or tick while idle, or the unused opcode) keeps
// the state idle. Each streamed byte passes a store read state, then a load
// state waiting on a free output. Configuration writes are accepted every cycle.
module command_packet_framer_unit import cpf_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [TICK_W-1:0] timeout_ticks,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  packet_length,
	output logic [CNT_W-1:0]  byte_index,
	output logic [BYTE_W-1:0] data_out,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [REG_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0] cfg_data
);

	localparam int FULL_LIMIT = (BUF_DEPTH < PKT_MAX) ? BUF_DEPTH : PKT_MAX;
	localparam int AW         = $clog2(FULL_LIMIT);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FULL_LIMIT);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_LOAD  = 2'd3;

	logic [1:0]        state_q;
	logic              active_q;
	logic              chk_ticks_q;
	logic              chk_type_q;
	logic [CNT_W-1:0]  widx_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] first_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] last_byte_q;
	logic [TICK_W-1:0] reload_q;
	logic [TICK_W-1:0] ticks_q;
	logic [CNT_W-1:0]  rd_k_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [CNT_W-1:0]  out_len_q;
	logic [CNT_W-1:0]  out_idx_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_last_q;

	logic              in_acc;
	logic              out_free;
	logic              is_mark;
	logic [CNT_W-1:0]  base_idx;
	logic [BYTE_W-1:0] base_sum;
	logic              can_store;
	logic              wr_en;
	logic              rd_en;
	logic [BYTE_W-1:0] rd_data;
	logic              type_hit;
	logic              end_hit;
	logic [BYTE_W-1:0] body_sum;
	logic              sum_ok;
	cfg_wr_t           cfg_wr;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;

	// Byte placement: a start marker restarts the packet
	assign is_mark   = (data_byte == START_MARK);
	assign base_idx  = is_mark ? '0 : widx_q;
	assign base_sum  = is_mark ? '0 : sum_q;
	assign can_store = (base_idx < FULL_CNT);
	assign wr_en     = in_acc && (opcode == OP_BYTE) && active_q && can_store;
	assign rd_en     = (state_q == ST_READ);

	// End-of-packet and checksum tests
	assign end_hit  = (widx_q >= FULL_CNT) || type_hit;
	assign body_sum = sum_q - last_byte_q;
	assign sum_ok   = (~body_sum == last_byte_q);

	cpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (cfg_wr),
		.type_byte (type_q),
		.count     (widx_q),
		.type_hit  (type_hit)
	);

	cpf_store #(
		.DEPTH (FULL_LIMIT),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (base_idx[AW-1:0]),
		.wr_data (data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_k_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Control: read state, sequencer and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			chk_ticks_q <= 1'b0;
			chk_type_q  <= 1'b0;
			widx_q      <= '0;
			sum_q       <= '0;
			type_q      <= '0;
			reload_q    <= '0;
			ticks_q     <= '0;
			rd_k_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the load state drives the output valid itself
			if (out_valid_q && out_ready && state_q != ST_LOAD)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (opcode)
							OP_START: begin
								widx_q      <= '0;
								sum_q       <= '0;
								type_q      <= '0;
								reload_q    <= timeout_ticks;
								ticks_q     <= timeout_ticks;
								active_q    <= 1'b1;
								chk_ticks_q <= 1'b1;
								chk_type_q  <= 1'b1;
								state_q     <= ST_CHECK;
							end
							OP_BYTE: begin
								if (active_q) begin
									if (can_store) begin
										widx_q <= base_idx + 1'b1;
										sum_q  <= base_sum + data_byte;
										if (base_idx == CNT_W'(1))
											type_q <= data_byte;
									end else begin
										widx_q <= base_idx;
										sum_q  <= base_sum;
									end
									ticks_q     <= reload_q;
									chk_ticks_q <= 1'b0;
									chk_type_q  <= 1'b1;
									state_q     <= ST_CHECK;
								end
							end
							OP_TICK: begin
								if (active_q) begin
									if (ticks_q != '0)
										ticks_q <= ticks_q - 1'b1;
									chk_ticks_q <= 1'b1;
									chk_type_q  <= 1'b0;
									state_q     <= ST_CHECK;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					state_q <= ST_IDLE;
					if ((chk_ticks_q && ticks_q == '0) || (chk_type_q && end_hit)) begin
						active_q <= 1'b0;
						if (widx_q == '0 || first_q != START_MARK || !sum_ok) begin
							out_valid_q <= 1'b1;
						end else begin
							rd_k_q  <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						rd_k_q      <= rd_k_q + 1'b1;
						state_q     <= (rd_k_q == widx_q - 1'b1) ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Packet bytes kept beside the store for the checks
	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_byte_q <= data_byte;
			if (base_idx == '0)
				first_q <= data_byte;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			out_len_q  <= widx_q;
			out_idx_q  <= '0;
			out_data_q <= '0;
			out_last_q <= 1'b1;
			if (widx_q == '0)
				out_status_q <= STS_NO_DATA;
			else if (first_q != START_MARK)
				out_status_q <= STS_NO_START;
			else
				out_status_q <= STS_BAD_SUM;
		end else if (state_q == ST_LOAD && out_free) begin
			out_status_q <= STS_OK;
			out_len_q    <= widx_q;
			out_idx_q    <= rd_k_q;
			out_data_q   <= rd_data;
			out_last_q   <= (rd_k_q == widx_q - 1'b1);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign packet_length = out_len_q;
	assign byte_index    = out_idx_q;
	assign data_out      = out_data_q;
	assign last          = out_last_q;

endmodule
